[rtl/core/npcs_pkg.sv]
// Shared constants and item codes for the nearest palette colour search.
`default_nettype none

package npcs_pkg;

    localparam int CHANNEL_BITS               = 8;
    localparam int INDEX_BITS                 = 8;
    localparam int DIST_BITS                  = 18;
    localparam int SQUARE_BITS                = 2 * CHANNEL_BITS;
    localparam int OUT_DATA_BITS              = 32;
    localparam int DEF_PALETTE_ENTRIES        = 256;
    localparam int DEF_QUERY_CHANNEL_BITS     = 6;

    localparam logic [DIST_BITS-1:0] DIST_START = '1;
    localparam logic [DIST_BITS-1:0] DIST_MAX   = DIST_BITS'(3 * 255 * 255);

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

endpackage

`default_nettype wire

[rtl/core/npcs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module npcs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/nearest_palette_color_search.sv]
// Top level of the nearest palette colour search: palette store and scan sequencer.
// A palette write item gives no result.
// A query item reads one palette entry per cycle, then squares and compares in two stages;
// its result enters the output register once the pipeline is empty; the next item can be
// taken in that same cycle. Input stalls while a query scans or its result waits for the
// output register. Reset clears the per-entry valid bits, so the palette reads as black.
`default_nettype none

module nearest_palette_color_search #(
    parameter int PALETTE_ENTRIES    = npcs_pkg::DEF_PALETTE_ENTRIES,
    parameter int QUERY_CHANNEL_BITS = npcs_pkg::DEF_QUERY_CHANNEL_BITS,
    parameter int IN_DATA_BITS       =
        ((4 * npcs_pkg::CHANNEL_BITS + 3 * QUERY_CHANNEL_BITS + 7) / 8) * 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // entry_index, entry_red, entry_green, entry_blue, query_red, query_green, query_blue
    input  wire logic [IN_DATA_BITS-1:0]            s_axis_tdata,
    // func
    input  wire logic                               s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // best_index, best_distance
    output logic      [npcs_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

    import npcs_pkg::*;

    localparam int ADDR_BITS   = $clog2(PALETTE_ENTRIES);
    localparam int ENTRY_BITS  = 3 * CHANNEL_BITS;
    localparam int QUERY_SHIFT = CHANNEL_BITS - QUERY_CHANNEL_BITS;
    localparam int ER_LSB      = INDEX_BITS;
    localparam int EG_LSB      = ER_LSB + CHANNEL_BITS;
    localparam int EB_LSB      = EG_LSB + CHANNEL_BITS;
    localparam int QR_LSB      = EB_LSB + CHANNEL_BITS;
    localparam int QG_LSB      = QR_LSB + QUERY_CHANNEL_BITS;
    localparam int QB_LSB      = QG_LSB + QUERY_CHANNEL_BITS;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    function automatic logic [CHANNEL_BITS-1:0] abs_diff(
        input logic [CHANNEL_BITS-1:0] a,
        input logic [CHANNEL_BITS-1:0] b
    );
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    state_t                      state_reg, state_next;
    logic [ADDR_BITS-1:0]        scan_addr_reg, scan_addr_next;
    logic [PALETTE_ENTRIES-1:0]  valid_reg;
    logic [CHANNEL_BITS-1:0]     qr_reg, qg_reg, qb_reg;
    logic                        p1_vld_reg, p2_vld_reg;
    logic                        p1_live_reg;
    logic [ADDR_BITS-1:0]        p1_idx_reg, p2_idx_reg;
    logic [SQUARE_BITS-1:0]      sq_r_reg, sq_g_reg, sq_b_reg;
    logic [DIST_BITS-1:0]        best_d_reg, best_d_next;
    logic [ADDR_BITS-1:0]        best_idx_reg, best_idx_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_BITS-1:0]    m_tdata_reg, m_tdata_next;

    logic                        in_accept;
    logic                        wr_en;
    logic [ADDR_BITS-1:0]        wr_addr;
    logic [ENTRY_BITS-1:0]       wr_data;
    logic                        rd_en;
    logic [ENTRY_BITS-1:0]       rd_data;
    logic [CHANNEL_BITS-1:0]     ent_r, ent_g, ent_b;
    logic [DIST_BITS-1:0]        cand_dist;
    logic                        pipe_empty;
    logic                        out_free;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign wr_en     = in_accept && (s_axis_tuser == FUNC_WRITE)
                       && ({1'b0, s_axis_tdata[INDEX_BITS-1:0]}
                           < (INDEX_BITS + 1)'(PALETTE_ENTRIES));
    assign wr_addr   = s_axis_tdata[ADDR_BITS-1:0];
    assign wr_data   = {s_axis_tdata[EB_LSB +: CHANNEL_BITS],
                        s_axis_tdata[EG_LSB +: CHANNEL_BITS],
                        s_axis_tdata[ER_LSB +: CHANNEL_BITS]};
    assign rd_en     = (state_reg == S_SCAN);

    npcs_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (scan_addr_reg),
        .rd_data (rd_data)
    );

    assign ent_r = p1_live_reg ? rd_data[0 +: CHANNEL_BITS]            : '0;
    assign ent_g = p1_live_reg ? rd_data[CHANNEL_BITS +: CHANNEL_BITS] : '0;
    assign ent_b = p1_live_reg ? rd_data[2*CHANNEL_BITS +: CHANNEL_BITS] : '0;

    assign cand_dist  = DIST_BITS'(sq_r_reg) + DIST_BITS'(sq_g_reg) + DIST_BITS'(sq_b_reg);
    assign pipe_empty = !p1_vld_reg && !p2_vld_reg;
    assign out_free   = !m_tvalid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    always_comb
    begin
        state_next     = state_reg;
        scan_addr_next = scan_addr_reg;
        best_d_next    = best_d_reg;
        best_idx_next  = best_idx_reg;
        m_tvalid_next  = m_tvalid_reg && !m_axis_tready;
        m_tdata_next   = m_tdata_reg;

        if (p2_vld_reg && (cand_dist < best_d_reg))
        begin
            best_d_next   = cand_dist;
            best_idx_next = p2_idx_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (s_axis_tuser == FUNC_QUERY))
                begin
                    scan_addr_next = '0;
                    best_d_next    = DIST_START;
                    best_idx_next  = '0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_addr_reg == ADDR_BITS'(PALETTE_ENTRIES - 1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (pipe_empty && out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_DATA_BITS'({best_d_reg, INDEX_BITS'(best_idx_reg)});
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            p1_vld_reg   <= 1'b0;
            p2_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            p1_vld_reg   <= rd_en;
            p2_vld_reg   <= p1_vld_reg;
            m_tvalid_reg <= m_tvalid_next;
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_addr_reg <= scan_addr_next;
        best_d_reg    <= best_d_next;
        best_idx_reg  <= best_idx_next;
        m_tdata_reg   <= m_tdata_next;
        p1_idx_reg    <= scan_addr_reg;
        p1_live_reg   <= valid_reg[scan_addr_reg];
        p2_idx_reg    <= p1_idx_reg;
        sq_r_reg      <= abs_diff(ent_r, qr_reg) * abs_diff(ent_r, qr_reg);
        sq_g_reg      <= abs_diff(ent_g, qg_reg) * abs_diff(ent_g, qg_reg);
        sq_b_reg      <= abs_diff(ent_b, qb_reg) * abs_diff(ent_b, qb_reg);
        if (in_accept && (s_axis_tuser == FUNC_QUERY))
        begin
            qr_reg <= CHANNEL_BITS'(s_axis_tdata[QR_LSB +: QUERY_CHANNEL_BITS]) << QUERY_SHIFT;
            qg_reg <= CHANNEL_BITS'(s_axis_tdata[QG_LSB +: QUERY_CHANNEL_BITS]) << QUERY_SHIFT;
            qb_reg <= CHANNEL_BITS'(s_axis_tdata[QB_LSB +: QUERY_CHANNEL_BITS]) << QUERY_SHIFT;
        end
    end

endmodule

`default_nettype wire

[rtl/core/npcs_checker.sv]
// Port-level assertions for the nearest palette colour search, bound to the top level.
`default_nettype none

module npcs_checker #(
    parameter int PALETTE_ENTRIES    = npcs_pkg::DEF_PALETTE_ENTRIES,
    parameter int QUERY_CHANNEL_BITS = npcs_pkg::DEF_QUERY_CHANNEL_BITS,
    parameter int IN_DATA_BITS       =
        ((4 * npcs_pkg::CHANNEL_BITS + 3 * QUERY_CHANNEL_BITS + 7) / 8) * 8
) (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_axis_tvalid,
    input wire logic                               s_axis_tready,
    input wire logic [IN_DATA_BITS-1:0]            s_axis_tdata,
    input wire logic                               s_axis_tuser,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [npcs_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

    import npcs_pkg::*;

    logic in_query;
    logic in_write;

    assign in_query = s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_QUERY);
    assign in_write = s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_WRITE);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_query |=> !s_axis_tready)
        else $error("input ready while a query scans");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_write && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("palette write produced a result item");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[INDEX_BITS +: DIST_BITS] <= DIST_MAX)
        else $error("distance beyond the largest possible value");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            {1'b0, m_axis_tdata[INDEX_BITS-1:0]} < (INDEX_BITS + 1)'(PALETTE_ENTRIES))
        else $error("index beyond the palette");

endmodule

bind nearest_palette_color_search npcs_checker #(
    .PALETTE_ENTRIES    (PALETTE_ENTRIES),
    .QUERY_CHANNEL_BITS (QUERY_CHANNEL_BITS),
    .IN_DATA_BITS       (IN_DATA_BITS)
) u_npcs_checker (.*);

`default_nettype wire

[test/tb_nearest_palette_color_search.sv]
`timescale 1ns / 100ps
// Testbench for the nearest palette colour search: palette writes and queries against a scan predictor.
module tb_nearest_palette_color_search;
    import npcs_pkg::*;

    localparam int IN_BITS      =
        ((4 * CHANNEL_BITS + 3 * DEF_QUERY_CHANNEL_BITS + 7) / 8) * 8;
    localparam int QBITS        = DEF_QUERY_CHANNEL_BITS;
    localparam int ITEM_TARGET  = 700;
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 800;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed
    {
        logic [INDEX_BITS-1:0] index;
        logic [DIST_BITS-1:0]  distance;
    } match_t;

    class match_board;
        logic [3*CHANNEL_BITS-1:0] palette [DEF_PALETTE_ENTRIES];
        match_t                    expected_matches [$];
        int                        errors;

        function new();
            foreach (palette[i])
            begin
                palette[i] = '0;
            end
            errors = 0;
        endfunction

        function match_t nearest_entry(logic [QBITS-1:0] qr, logic [QBITS-1:0] qg,
                                       logic [QBITS-1:0] qb);
            match_t m;
            int     best_d;
            int     d;
            int     dr;
            int     dg;
            int     db;
            best_d     = 32'h7FFF_FFFF;
            m.index    = '0;
            m.distance = '0;
            for (int p = 0; p < DEF_PALETTE_ENTRIES; p++)
            begin
                dr = int'(palette[p][7:0])   - int'({qr, 2'b00});
                dg = int'(palette[p][15:8])  - int'({qg, 2'b00});
                db = int'(palette[p][23:16]) - int'({qb, 2'b00});
                d  = dr * dr + dg * dg + db * db;
                if (d < best_d)
                begin
                    best_d     = d;
                    m.index    = INDEX_BITS'(p);
                    m.distance = DIST_BITS'(d);
                end
            end
            return m;
        endfunction

        function void note_item(logic func, logic [IN_BITS-1:0] data);
            if (func == FUNC_WRITE)
                palette[data[7:0]] = data[31:8];
            else
                expected_matches.push_back(nearest_entry(data[37:32], data[43:38],
                                                         data[49:44]));
        endfunction

        function void check_result(logic [OUT_DATA_BITS-1:0] data);
            match_t want;
            if (expected_matches.size() == 0)
            begin
                $display("%0t: result with nothing expected: expected none, got %h",
                         $time, data);
                errors++;
                return;
            end
            want = expected_matches.pop_front();
            if (data[7:0] !== want.index)
            begin
                $display("%0t: best_index expected %0d, got %0d",
                         $time, want.index, data[7:0]);
                errors++;
            end
            if (data[25:8] !== want.distance)
            begin
                $display("%0t: best_distance expected %0d, got %0d",
                         $time, want.distance, data[25:8]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_matches.size();
        endfunction
    endclass

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_BITS-1:0] s_axis_tdata  = '0;
    logic               s_axis_tuser  = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;

    match_board board = new();
    int         items_sent    = 0;
    int         results_taken = 0;
    int         quiet_cycles  = 0;
    int         tx_idle_pct   = 20;
    int         rx_idle_pct   = 48;
    bit         held          = 1'b0;

    nearest_palette_color_search dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_item(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                board.check_result(m_axis_tdata);
                results_taken++;
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_nearest_palette_color_search NOT OK");
                $finish;
            end
        end
    end

    // hold the result side off once for a long stretch so the block backs up
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!held && results_taken >= 30)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                held = 1'b1;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    function automatic logic [IN_BITS-1:0] pack_item(
        logic [7:0] ei, logic [7:0] er, logic [7:0] eg, logic [7:0] eb,
        logic [QBITS-1:0] qr, logic [QBITS-1:0] qg, logic [QBITS-1:0] qb);
        return {{(IN_BITS - 4 * CHANNEL_BITS - 3 * QBITS){1'b0}}, qb, qg, qr, eb, eg, er, ei};
    endfunction

    function automatic logic [7:0] near_level(logic [QBITS-1:0] q);
        int v;
        v = int'({q, 2'b00}) + $urandom_range(0, 8) - 4;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    task automatic send_item(input logic func, input logic [IN_BITS-1:0] data);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= func;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
        if (items_sent == ITEM_TARGET / 3)
        begin
            tx_idle_pct = 48;
            rx_idle_pct = 20;
        end
        else if (items_sent == 2 * ITEM_TARGET / 3)
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    task automatic write_entry(input logic [7:0] idx, input logic [7:0] r,
                               input logic [7:0] g, input logic [7:0] b);
        send_item(FUNC_WRITE, pack_item(idx, r, g, b, QBITS'($urandom),
                                        QBITS'($urandom), QBITS'($urandom)));
    endtask

    task automatic query_colour(input logic [QBITS-1:0] qr, input logic [QBITS-1:0] qg,
                                input logic [QBITS-1:0] qb);
        send_item(FUNC_QUERY, pack_item(8'($urandom), 8'($urandom), 8'($urandom),
                                        8'($urandom), qr, qg, qb));
    endtask

    // one to four rounds of writes, random or near a target colour (some as tied pairs), then the query itself
    task automatic play_sequence();
        logic [QBITS-1:0] qr;
        logic [QBITS-1:0] qg;
        logic [QBITS-1:0] qb;
        logic [7:0]       r;
        logic [7:0]       g;
        logic [7:0]       b;
        int               writes;
        qr     = QBITS'($urandom);
        qg     = QBITS'($urandom);
        qb     = QBITS'($urandom);
        writes = $urandom_range(1, 4);
        for (int w = 0; w < writes; w++)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    write_entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                end
                1:
                begin
                    write_entry(8'($urandom), near_level(qr), near_level(qg), near_level(qb));
                end
                default:
                begin
                    r = near_level(qr);
                    g = near_level(qg);
                    b = near_level(qb);
                    write_entry(8'($urandom), r, g, b);
                    write_entry(8'($urandom), r, g, b);
                end
            endcase
        end
        query_colour(qr, qg, qb);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        query_colour('0, '0, '0);
        query_colour('1, '1, '1);
        write_entry(8'd255, 8'd255, 8'd255, 8'd255);
        query_colour('1, '1, '1);
        write_entry(8'd0, 8'd255, 8'd255, 8'd255);
        query_colour('1, '1, '1);
        write_entry(8'd100, 8'd252, 8'd252, 8'd252);
        query_colour('1, '1, '1);
        query_colour('0, '0, '0);
        write_entry(8'd1, 8'hAA, 8'h55, 8'hF0);
        query_colour(6'd42, 6'd21, 6'd60);
        query_colour(6'h2A, 6'h15, 6'h2A);

        // flood the palette white for the farthest possible match
        for (int i = 0; i < DEF_PALETTE_ENTRIES; i++)
            write_entry(8'(i), 8'd255, 8'd255, 8'd255);
        query_colour('0, '0, '0);
        query_colour('1, '1, '1);

        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 99) < 70)
                play_sequence();
            else if ($urandom_range(0, 1) == 0)
                write_entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            else
                query_colour(QBITS'($urandom), QBITS'($urandom), QBITS'($urandom));
        end
        s_axis_tvalid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("tb_nearest_palette_color_search OK");
        else
            $display("tb_nearest_palette_color_search NOT OK");
        $finish;
    end

endmodule
